// ----- design/alpd_pkg.sv -----
// ----------------------------------------------------------------------------
// alpd_pkg
// Shared types and constants for the adaptive light pulse detector.
// ----------------------------------------------------------------------------
package alpd_pkg;

    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int SAMPLE_W = 11;
    localparam int TOL_W    = LEVEL_W - 3;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP     = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR   = 8'd0;
    localparam logic [LEVEL_W-1:0] MIN_SWING_RST = 8'd30;
    localparam logic [LEVEL_W:0]   DRIFT_MARGIN  = 9'd2;

    localparam logic [1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [1:0] MODE_REPORT  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic CFG_ENABLE    = 1'b0;
    localparam logic CFG_MIN_SWING = 1'b1;

    typedef enum logic [1:0] {
        PH_INITIAL = 2'd0,
        PH_LOW     = 2'd1,
        PH_HIGH    = 2'd2
    } alpd_phase_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] sample;
    } alpd_in_t;

    typedef struct packed {
        logic               pulse;
        logic [COUNT_W-1:0] pulses;
        logic [LEVEL_W-1:0] track_min;
        logic [LEVEL_W-1:0] track_max;
        logic [1:0]         phase;
    } alpd_out_t;

    typedef struct packed {
        logic               enable;
        logic [LEVEL_W-1:0] min_swing;
    } alpd_cfg_t;

endpackage

// ----- design/adaptive_light_pulse_detector.sv -----
// ----------------------------------------------------------------------------
// adaptive_light_pulse_detector
// Light pulse detector with self-adjusting thresholds and a pulse counter.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while in_stall is low and gives one result
// item per input item. An item is captured in an input register, processed
// there by the tracking logic and loaded into a result register when that
// register is empty or being taken; the result is offered until taken.
// Throughput is set by the single tracking state update per cycle, made only
// when a result is loaded. Output stall reaches in_stall combinationally, and
// in_stall is never raised while the result register is empty. Configuration
// writes take effect on the next cycle.
module adaptive_light_pulse_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [alpd_pkg::LEVEL_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  alpd_pkg::alpd_in_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output alpd_pkg::alpd_out_t           out_item
);
    import alpd_pkg::*;

    alpd_cfg_t cfg;
    alpd_out_t result;

    logic      in_valid_reg, in_valid_next;
    alpd_in_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    alpd_out_t out_item_reg;
    logic      in_take;
    logic      out_load;

    alpd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    alpd_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (out_load),
        .item   (in_item_reg),
        .result (result)
    );

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (out_load)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- design/alpd_cfg.sv -----
// ----------------------------------------------------------------------------
// alpd_cfg
// Configuration registers: enable and minimum swing.
// ----------------------------------------------------------------------------
module alpd_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic                     index,
    input  logic [alpd_pkg::LEVEL_W-1:0] data,
    output alpd_pkg::alpd_cfg_t      cfg
);
    import alpd_pkg::*;

    logic               enable_reg;
    logic               enable_next;
    logic [LEVEL_W-1:0] min_swing_reg;
    logic [LEVEL_W-1:0] min_swing_next;

    always_comb
    begin
        enable_next    = enable_reg;
        min_swing_next = min_swing_reg;
        if (we)
        begin
            unique case (index)
                CFG_ENABLE:    enable_next    = data[0];
                CFG_MIN_SWING: min_swing_next = data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            min_swing_reg <= MIN_SWING_RST;
        end
        else
        begin
            enable_reg    <= enable_next;
            min_swing_reg <= min_swing_next;
        end
    end

    assign cfg.enable    = enable_reg;
    assign cfg.min_swing = min_swing_reg;

endmodule

// ----- design/alpd_track.sv -----
// ----------------------------------------------------------------------------
// alpd_track
// Level tracking state, phase machine and pulse counter; forms one result
// per item from the registered input item.
// ----------------------------------------------------------------------------
module alpd_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alpd_pkg::alpd_cfg_t  cfg,
    input  logic                 fire,
    input  alpd_pkg::alpd_in_t   item,
    output alpd_pkg::alpd_out_t  result
);
    import alpd_pkg::*;

    logic [LEVEL_W-1:0] level_max_reg, level_max_next;
    logic [LEVEL_W-1:0] level_min_reg, level_min_next;
    logic [LEVEL_W-1:0] cycle_max_reg, cycle_max_next;
    logic [LEVEL_W-1:0] cycle_min_reg, cycle_min_next;
    alpd_phase_t        phase_reg, phase_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    logic [LEVEL_W-1:0] v;
    logic [LEVEL_W-1:0] lmax_s, lmin_s, cmax_s, cmin_s;
    logic [LEVEL_W-1:0] span;
    logic [TOL_W-1:0]   tol;
    logic [LEVEL_W-1:0] hi_thr;
    logic [LEVEL_W:0]   lo_thr;
    logic               above, below, min_lift, max_drop;
    logic               pulse;
    logic [COUNT_W-1:0] count_out;

    // reduced reading, clamped to the 8-bit range
    assign v = item.sample[SAMPLE_W-1] ? LEVEL_TOP : item.sample[SAMPLE_W-2:2];

    assign lmax_s = (v > level_max_reg) ? v : level_max_reg;
    assign lmin_s = (v < level_min_reg) ? v : level_min_reg;
    assign cmax_s = (v > cycle_max_reg) ? v : cycle_max_reg;
    assign cmin_s = (v < cycle_min_reg) ? v : cycle_min_reg;

    // v lies between lmin_s and lmax_s, so the span is never negative
    assign span   = lmax_s - lmin_s;
    assign tol    = span[LEVEL_W-1:3];
    assign hi_thr = lmax_s - {3'b000, tol};
    assign lo_thr = {1'b0, lmin_s} + {3'b000, tol, 1'b0};

    assign above    = v > hi_thr;
    assign below    = {1'b0, v} < lo_thr;
    assign min_lift = {1'b0, cmin_s} > ({1'b0, lmin_s} + DRIFT_MARGIN);
    assign max_drop = ({1'b0, cmax_s} + DRIFT_MARGIN) < {1'b0, lmax_s};

    always_comb
    begin
        level_max_next = level_max_reg;
        level_min_next = level_min_reg;
        cycle_max_next = cycle_max_reg;
        cycle_min_next = cycle_min_reg;
        phase_next     = phase_reg;
        total_next     = total_reg;
        pulse          = 1'b0;
        count_out      = total_reg;

        unique case (item.mode)
            MODE_SAMPLE:
            begin
                if (cfg.enable)
                begin
                    level_max_next = lmax_s;
                    level_min_next = lmin_s;
                    cycle_max_next = cmax_s;
                    cycle_min_next = cmin_s;
                    if (phase_reg == PH_INITIAL && span > cfg.min_swing)
                    begin
                        phase_next = above ? PH_HIGH : PH_LOW;
                    end
                    unique case (phase_next)
                        PH_LOW:
                        begin
                            if (above)
                            begin
                                phase_next     = PH_HIGH;
                                total_next     = total_reg + 1'b1;
                                pulse          = 1'b1;
                                if (min_lift)
                                begin
                                    level_min_next = cmin_s;
                                end
                                cycle_min_next = LEVEL_TOP;
                            end
                        end
                        PH_HIGH:
                        begin
                            if (below)
                            begin
                                phase_next = PH_LOW;
                                if (max_drop)
                                begin
                                    level_max_next = cmax_s;
                                end
                                cycle_max_next = LEVEL_FLOOR;
                            end
                        end
                        default: ;
                    endcase
                end
                count_out = total_next;
            end
            MODE_REPORT:
            begin
                total_next = '0;
            end
            MODE_RESTART:
            begin
                level_max_next = LEVEL_FLOOR;
                level_min_next = LEVEL_TOP;
                cycle_max_next = LEVEL_FLOOR;
                cycle_min_next = LEVEL_TOP;
                phase_next     = PH_INITIAL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_max_reg <= LEVEL_FLOOR;
            level_min_reg <= LEVEL_TOP;
            cycle_max_reg <= LEVEL_FLOOR;
            cycle_min_reg <= LEVEL_TOP;
            phase_reg     <= PH_INITIAL;
            total_reg     <= '0;
        end
        else if (fire)
        begin
            level_max_reg <= level_max_next;
            level_min_reg <= level_min_next;
            cycle_max_reg <= cycle_max_next;
            cycle_min_reg <= cycle_min_next;
            phase_reg     <= phase_next;
            total_reg     <= total_next;
        end
    end

    assign result.pulse     = pulse;
    assign result.pulses    = count_out;
    assign result.track_min = level_min_next;
    assign result.track_max = level_max_next;
    assign result.phase     = phase_next;

endmodule

// ----- design/alpd_checker.sv -----
// ----------------------------------------------------------------------------
// alpd_checker
// Port-level checks for the light pulse detector, bound to the top level.
// ----------------------------------------------------------------------------
module alpd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input alpd_pkg::alpd_in_t            in_item,
    input logic                          out_valid,
    input logic                          out_stall,
    input alpd_pkg::alpd_out_t           out_item
);
    import alpd_pkg::*;

    // a pulse is only reported on entry to the high area
    a_pulse_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.pulse |-> out_item.phase == PH_HIGH)
        else $error("pulse reported outside high area");

    // empty result register never back-pressures the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("stalled input item changed");

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item changed");

endmodule

bind adaptive_light_pulse_detector alpd_checker u_alpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
